// ===== hdl/sbm_pkg.sv =====
// Shared types and constants for the spectral band mask unit.
// Used by every module under hdl/; depends on nothing.
package sbm_pkg;

  localparam int MAX_BINS   = 4096;
  localparam int BIN_W      = $clog2(MAX_BINS + 1);
  localparam int IDX_W      = BIN_W + 1;
  localparam int DATA_W     = 32;
  localparam int FREQ_W     = 40;
  localparam int WIDTH_W    = 36;
  localparam int FRAC_W     = 24;
  localparam int RATIO_W    = 17;
  localparam int CFG_BINS_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam int S_TDATA_W  = 128;
  localparam int M_FIELDS_W = 2 * DATA_W + BIN_W + RATIO_W + 2 * FRAC_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  localparam int PROD_W     = WIDTH_W + BIN_W;
  localparam int DIV_NUM_W  = PROD_W + 2;
  localparam int DIV_DEN_W  = WIDTH_W + 2;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);
  localparam int RATIO_SHIFT = 17;

  localparam logic signed [FREQ_W-1:0] FULL_SPAN     = 40'sd65536000000;
  localparam logic [WIDTH_W-1:0]       WIDTH_RESET   = 36'd1048576;
  localparam logic [CFG_BINS_W-1:0]    BINS_RESET    = 13'd128;
  localparam logic [FRAC_W-1:0]        FRAC_MAX      = '1;
  localparam logic [RATIO_W-1:0]       RATIO_ONE     = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS   = 2'd3;

  typedef enum logic [1:0] {
    DIV_IDX,
    DIV_FRAC,
    DIV_RATIO
  } div_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BAND,
    ST_OFS,
    ST_SEL,
    ST_IDXW,
    ST_MASK,
    ST_FRAC,
    ST_FRACW,
    ST_RATIO,
    ST_RATIOW,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    band_latch;
    logic    ofs_load;
    logic    edge_sel;
    logic    idx_set;
    logic    div_start;
    div_op_t div_op;
    logic    quo_store;
    logic    mask_step;
    logic    emit;
  } sbm_cmd_t;

  typedef struct packed {
    logic first_bin;
    logic ofs_inside;
    logic need_stats;
    logic div_busy;
    logic out_free;
  } sbm_sts_t;

endpackage

// ===== hdl/sbm_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sbm_pkg for widths.
module sbm_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [sbm_pkg::DIV_NUM_W-1:0]   num,
  input  logic [sbm_pkg::DIV_DEN_W-1:0]   den,
  output logic                            busy,
  output logic [sbm_pkg::DIV_NUM_W-1:0]   quo
);

  logic [sbm_pkg::DIV_CNT_W-1:0] cnt;
  logic [sbm_pkg::DIV_DEN_W-1:0] rem;
  logic [sbm_pkg::DIV_DEN_W-1:0] den_r;
  logic [sbm_pkg::DIV_DEN_W:0]   trial;
  logic [sbm_pkg::DIV_DEN_W:0]   diff;
  logic                          ge;

  assign trial = {rem, quo[sbm_pkg::DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == sbm_pkg::DIV_CNT_W'(sbm_pkg::DIV_NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[sbm_pkg::DIV_DEN_W-1:0] : trial[sbm_pkg::DIV_DEN_W-1:0];
      quo <= {quo[sbm_pkg::DIV_NUM_W-2:0], ge};
    end
  end

endmodule

// ===== hdl/sbm_dp.sv =====
// Datapath: config registers, item capture, band index setup, bin masking,
// end-of-spectrum statistics and the output register. Uses sbm_pkg, sbm_div.
module sbm_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [sbm_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic                             s_tuser,
  input  logic                             s_tlast,
  input  sbm_pkg::sbm_cmd_t                cmd,
  output sbm_pkg::sbm_sts_t                sts,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [sbm_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                             m_tuser,
  output logic                             m_tlast
);

  localparam int PAD_W = sbm_pkg::M_TDATA_W - sbm_pkg::M_FIELDS_W;

  // config
  logic signed [sbm_pkg::FREQ_W-1:0]   edge_a;
  logic signed [sbm_pkg::FREQ_W-1:0]   edge_b;
  logic [sbm_pkg::WIDTH_W-1:0]         sb_width;
  logic [sbm_pkg::CFG_BINS_W-1:0]      bins_cfg;
  logic [sbm_pkg::BIN_W-1:0]           n_use;

  // captured item
  logic signed [sbm_pkg::DATA_W-1:0]   itm_real;
  logic signed [sbm_pkg::DATA_W-1:0]   itm_imag;
  logic                                itm_lsb;
  logic signed [sbm_pkg::FREQ_W-1:0]   itm_freq;
  logic [sbm_pkg::FRAC_W-1:0]          itm_frac;
  logic                                itm_last;

  // band state
  logic                                active;
  logic                                incl;
  logic [sbm_pkg::FRAC_W-1:0]          held;
  logic signed [sbm_pkg::FREQ_W-1:0]   lo_e;
  logic signed [sbm_pkg::FREQ_W-1:0]   hi_e;
  logic signed [sbm_pkg::FREQ_W:0]     bot;
  logic signed [sbm_pkg::FREQ_W:0]     top;
  logic [sbm_pkg::WIDTH_W-1:0]         ofs_d;
  logic                                ofs_below;
  logic                                ofs_inside;
  logic signed [sbm_pkg::IDX_W-1:0]    low_idx;
  logic signed [sbm_pkg::IDX_W-1:0]    high_idx;

  // per-spectrum counters and results
  logic [sbm_pkg::BIN_W-1:0]           pos;
  logic [sbm_pkg::BIN_W-1:0]           zeroed;
  logic [sbm_pkg::BIN_W-1:0]           res_zeroed;
  logic [sbm_pkg::BIN_W-1:0]           kept;
  logic                                need_stats;
  logic signed [sbm_pkg::DATA_W-1:0]   res_real;
  logic signed [sbm_pkg::DATA_W-1:0]   res_imag;
  logic [sbm_pkg::FRAC_W-1:0]          frac_res;
  logic [sbm_pkg::RATIO_W-1:0]         ratio_res;

  // combinational
  logic                                edge_lt;
  logic                                no_action;
  logic signed [sbm_pkg::FREQ_W:0]     f_ext;
  logic signed [sbm_pkg::FREQ_W:0]     w_ext;
  logic signed [sbm_pkg::FREQ_W:0]     v_ext;
  logic signed [sbm_pkg::FREQ_W:0]     dlt;
  logic signed [sbm_pkg::IDX_W-1:0]    idx_np1;
  logic signed [sbm_pkg::IDX_W-1:0]    idx_special;
  logic signed [sbm_pkg::IDX_W-1:0]    idx_quo;
  logic signed [sbm_pkg::IDX_W-1:0]    pos_s;
  logic                                zero_bin;
  logic [sbm_pkg::BIN_W-1:0]           zeroed_inc;
  logic [sbm_pkg::WIDTH_W-1:0]         mul_a;
  logic [sbm_pkg::PROD_W-1:0]          prod;
  logic [sbm_pkg::DIV_NUM_W-1:0]       div_num;
  logic [sbm_pkg::DIV_DEN_W-1:0]       div_den;
  logic                                div_busy;
  logic [sbm_pkg::DIV_NUM_W-1:0]       div_quo;
  logic [sbm_pkg::FRAC_W-1:0]          quo_sat;
  logic [sbm_pkg::BIN_W-1:0]           o_zeroed;
  logic [sbm_pkg::RATIO_W-1:0]         o_ratio;
  logic [sbm_pkg::FRAC_W-1:0]          o_frac;
  logic [sbm_pkg::FRAC_W-1:0]          o_saved;
  logic                                out_free;

  assign n_use = (32'(bins_cfg) > 32'(sbm_pkg::MAX_BINS)) ?
                 sbm_pkg::BIN_W'(sbm_pkg::MAX_BINS) : sbm_pkg::BIN_W'(bins_cfg);

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_a   <= '0;
      edge_b   <= sbm_pkg::FULL_SPAN;
      sb_width <= sbm_pkg::WIDTH_RESET;
      bins_cfg <= sbm_pkg::BINS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbm_pkg::CFG_EDGE_A: edge_a   <= cfg_data;
        sbm_pkg::CFG_EDGE_B: edge_b   <= cfg_data;
        sbm_pkg::CFG_WIDTH:  sb_width <= cfg_data[sbm_pkg::WIDTH_W-1:0];
        sbm_pkg::CFG_BINS:   bins_cfg <= cfg_data[sbm_pkg::CFG_BINS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      itm_real <= s_tdata[31:0];
      itm_imag <= s_tdata[63:32];
      itm_freq <= s_tdata[103:64];
      itm_frac <= s_tdata[127:104];
      itm_lsb  <= s_tuser;
      itm_last <= s_tlast;
    end
  end

  // band edges
  assign edge_lt   = edge_a < edge_b;
  assign no_action = (edge_a == edge_b) || (edge_a == '0 && edge_b == sbm_pkg::FULL_SPAN);
  assign f_ext     = (sbm_pkg::FREQ_W + 1)'(itm_freq);
  assign w_ext     = {5'b0, sb_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      incl   <= 1'b0;
      held   <= '0;
    end else if (cmd.band_latch) begin
      active <= !no_action;
      incl   <= edge_lt;
      held   <= itm_frac;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.band_latch) begin
      lo_e <= edge_lt ? edge_a : edge_b;
      hi_e <= edge_lt ? edge_b : edge_a;
      bot  <= itm_lsb ? f_ext - w_ext : f_ext;
      top  <= itm_lsb ? f_ext : f_ext + w_ext;
    end
  end

  // offset of one edge inside the sideband
  assign v_ext = (cmd.edge_sel ^ itm_lsb) ? (sbm_pkg::FREQ_W + 1)'(hi_e)
                                          : (sbm_pkg::FREQ_W + 1)'(lo_e);
  assign dlt   = itm_lsb ? top - v_ext : v_ext - bot;

  always_ff @(posedge clk) begin
    if (cmd.ofs_load) begin
      ofs_below  <= v_ext < bot;
      ofs_inside <= !(v_ext < bot) && (v_ext < top);
      ofs_d      <= dlt[sbm_pkg::WIDTH_W-1:0];
    end
  end

  assign idx_np1     = $signed({1'b0, n_use}) + sbm_pkg::IDX_W'(1);
  assign idx_special = (ofs_below ^ itm_lsb) ? '1 : idx_np1;
  assign idx_quo     = $signed({1'b0, div_quo[sbm_pkg::BIN_W-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      low_idx  <= '0;
      high_idx <= '0;
    end else if (cmd.idx_set || (cmd.quo_store && cmd.div_op == sbm_pkg::DIV_IDX)) begin
      if (cmd.edge_sel) begin
        high_idx <= cmd.idx_set ? idx_special : idx_quo;
      end else begin
        low_idx <= cmd.idx_set ? idx_special : idx_quo;
      end
    end
  end

  // divider operands
  assign mul_a = (cmd.div_op == sbm_pkg::DIV_IDX) ? ofs_d : sbm_pkg::WIDTH_W'(held);
  assign prod  = sbm_pkg::PROD_W'(mul_a) * sbm_pkg::PROD_W'(n_use);

  always_comb begin
    unique case (cmd.div_op)
      sbm_pkg::DIV_IDX: begin
        div_num = sbm_pkg::DIV_NUM_W'({prod, 1'b0}) + sbm_pkg::DIV_NUM_W'(sb_width);
        div_den = sbm_pkg::DIV_DEN_W'({sb_width, 1'b0});
      end
      sbm_pkg::DIV_FRAC: begin
        div_num = sbm_pkg::DIV_NUM_W'({prod, 1'b0}) + sbm_pkg::DIV_NUM_W'(kept);
        div_den = sbm_pkg::DIV_DEN_W'({kept, 1'b0});
      end
      default: begin
        div_num = sbm_pkg::DIV_NUM_W'({kept, {sbm_pkg::RATIO_SHIFT{1'b0}}})
                + sbm_pkg::DIV_NUM_W'(n_use);
        div_den = sbm_pkg::DIV_DEN_W'({n_use, 1'b0});
      end
    endcase
  end

  sbm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign quo_sat = (|div_quo[sbm_pkg::DIV_NUM_W-1:sbm_pkg::FRAC_W]) ?
                   sbm_pkg::FRAC_MAX : div_quo[sbm_pkg::FRAC_W-1:0];

  // bin masking
  assign pos_s    = $signed({1'b0, pos});
  assign zero_bin = active && (pos < n_use) &&
                    (incl ? (pos_s < low_idx || pos_s > high_idx)
                          : (pos_s > low_idx && pos_s < high_idx));
  assign zeroed_inc = zeroed + sbm_pkg::BIN_W'(zero_bin);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      zeroed     <= '0;
      need_stats <= 1'b0;
    end else if (cmd.mask_step) begin
      need_stats <= itm_last && active && (zeroed_inc < n_use);
      if (itm_last) begin
        pos    <= '0;
        zeroed <= '0;
      end else begin
        zeroed <= zeroed_inc;
        if (pos < sbm_pkg::BIN_W'(sbm_pkg::MAX_BINS)) begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mask_step) begin
      res_real   <= zero_bin ? '0 : itm_real;
      res_imag   <= zero_bin ? '0 : itm_imag;
      res_zeroed <= zeroed_inc;
      kept       <= n_use - zeroed_inc;
      frac_res   <= '0;
      ratio_res  <= '0;
    end else if (cmd.quo_store && cmd.div_op == sbm_pkg::DIV_FRAC) begin
      frac_res <= quo_sat;
    end else if (cmd.quo_store && cmd.div_op == sbm_pkg::DIV_RATIO) begin
      ratio_res <= div_quo[sbm_pkg::RATIO_W-1:0];
    end
  end

  // result fields
  always_comb begin
    o_zeroed = '0;
    o_ratio  = '0;
    o_frac   = '0;
    o_saved  = '0;
    if (itm_last) begin
      if (!active) begin
        o_ratio = sbm_pkg::RATIO_ONE;
        o_frac  = held;
      end else begin
        o_zeroed = res_zeroed;
        o_ratio  = ratio_res;
        o_frac   = frac_res;
        o_saved  = held;
      end
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {{PAD_W{1'b0}}, o_saved, o_frac, o_ratio, o_zeroed, res_imag, res_real};
      m_tuser <= active;
      m_tlast <= itm_last;
    end
  end

  assign sts.first_bin  = (pos == '0);
  assign sts.ofs_inside = ofs_inside;
  assign sts.need_stats = need_stats;
  assign sts.div_busy   = div_busy;
  assign sts.out_free   = out_free;

endmodule

// ===== hdl/sbm_ctrl.sv =====
// Controller: sequences band setup, masking, statistics and result hand-off.
// Depends on sbm_pkg for the state, command and status types.
module sbm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  sbm_pkg::sbm_sts_t sts,
  output sbm_pkg::sbm_cmd_t cmd
);

  sbm_pkg::state_t state;
  sbm_pkg::state_t state_next;
  logic            edge_sel;
  logic            edge_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sbm_pkg::ST_IDLE;
      edge_sel <= 1'b0;
    end else begin
      state    <= state_next;
      edge_sel <= edge_sel_next;
    end
  end

  always_comb begin
    state_next    = state;
    edge_sel_next = edge_sel;
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.edge_sel  = edge_sel;
    cmd.div_op    = sbm_pkg::DIV_IDX;
    unique case (state)
      sbm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = sts.first_bin ? sbm_pkg::ST_BAND : sbm_pkg::ST_MASK;
        end
      end
      sbm_pkg::ST_BAND: begin
        cmd.band_latch = 1'b1;
        edge_sel_next  = 1'b0;
        state_next     = sbm_pkg::ST_OFS;
      end
      sbm_pkg::ST_OFS: begin
        cmd.ofs_load = 1'b1;
        state_next   = sbm_pkg::ST_SEL;
      end
      sbm_pkg::ST_SEL: begin
        if (sts.ofs_inside) begin
          cmd.div_start = 1'b1;
          state_next    = sbm_pkg::ST_IDXW;
        end else begin
          cmd.idx_set = 1'b1;
          if (edge_sel) begin
            state_next = sbm_pkg::ST_MASK;
          end else begin
            edge_sel_next = 1'b1;
            state_next    = sbm_pkg::ST_OFS;
          end
        end
      end
      sbm_pkg::ST_IDXW: begin
        if (!sts.div_busy) begin
          cmd.quo_store = 1'b1;
          if (edge_sel) begin
            state_next = sbm_pkg::ST_MASK;
          end else begin
            edge_sel_next = 1'b1;
            state_next    = sbm_pkg::ST_OFS;
          end
        end
      end
      sbm_pkg::ST_MASK: begin
        cmd.mask_step = 1'b1;
        state_next    = sbm_pkg::ST_FRAC;
      end
      sbm_pkg::ST_FRAC: begin
        cmd.div_op = sbm_pkg::DIV_FRAC;
        if (sts.need_stats) begin
          cmd.div_start = 1'b1;
          state_next    = sbm_pkg::ST_FRACW;
        end else begin
          state_next = sbm_pkg::ST_EMIT;
        end
      end
      sbm_pkg::ST_FRACW: begin
        cmd.div_op = sbm_pkg::DIV_FRAC;
        if (!sts.div_busy) begin
          cmd.quo_store = 1'b1;
          state_next    = sbm_pkg::ST_RATIO;
        end
      end
      sbm_pkg::ST_RATIO: begin
        cmd.div_op    = sbm_pkg::DIV_RATIO;
        cmd.div_start = 1'b1;
        state_next    = sbm_pkg::ST_RATIOW;
      end
      sbm_pkg::ST_RATIOW: begin
        cmd.div_op = sbm_pkg::DIV_RATIO;
        if (!sts.div_busy) begin
          cmd.quo_store = 1'b1;
          state_next    = sbm_pkg::ST_EMIT;
        end
      end
      sbm_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sbm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/spectral_band_mask_unit.sv =====
// Spectral band mask unit: one request at a time. A middle bin passes the mask,
// fraction and emit states into the output register; a new request waits for idle.
// A first bin adds two band indices, each a divide if its edge is in the sideband;
// a last bin of an active band with kept bins adds the fraction and ratio divides.
// Output backpressure adds its wait; the shared serial divider sets the rest.
// Reset is synchronous and returns config, control state and counters to defaults.
module spectral_band_mask_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // bin_real, bin_imag, channel_freq, old_fraction
  input  logic [sbm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // lower_sideband
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_real, out_imag, bins_zeroed, kept_ratio, new_fraction, saved_fraction
  output logic [sbm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // action_taken
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);

  sbm_pkg::sbm_cmd_t cmd;
  sbm_pkg::sbm_sts_t sts;

  sbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .s_tlast   (s_axis_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .m_tready  (m_axis_tready),
    .m_tvalid  (m_axis_tvalid),
    .m_tdata   (m_axis_tdata),
    .m_tuser   (m_axis_tuser),
    .m_tlast   (m_axis_tlast)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking bench for spectral_band_mask_unit: streams spectra of bins
// through the unit and checks each output bin against a local mask predictor.
// Depends on hdl/sbm_pkg.sv and hdl/spectral_band_mask_unit.sv.
module tb;

  typedef struct packed {
    logic [sbm_pkg::DATA_W-1:0] re;
    logic [sbm_pkg::DATA_W-1:0] im;
    logic                       lsb;
    logic [sbm_pkg::FREQ_W-1:0] freq;
    logic [sbm_pkg::FRAC_W-1:0] frac;
    logic                       last;
  } bin_t;

  typedef struct packed {
    logic [sbm_pkg::DATA_W-1:0]  re;
    logic [sbm_pkg::DATA_W-1:0]  im;
    logic                        eos;
    logic                        act;
    logic [sbm_pkg::BIN_W-1:0]   zeroed;
    logic [sbm_pkg::RATIO_W-1:0] ratio;
    logic [sbm_pkg::FRAC_W-1:0]  nfrac;
    logic [sbm_pkg::FRAC_W-1:0]  sfrac;
  } res_t;

  localparam logic [sbm_pkg::DATA_W-1:0] CORNER [4] =
    '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
  localparam longint MHZ = 65536;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [sbm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sbm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [sbm_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           s_axis_tlast = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [sbm_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tlast;

  spectral_band_mask_unit uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of config and state
  logic signed [sbm_pkg::FREQ_W-1:0] edge_a = '0;
  logic signed [sbm_pkg::FREQ_W-1:0] edge_b = sbm_pkg::FULL_SPAN;
  logic [sbm_pkg::WIDTH_W-1:0]       sb_width = sbm_pkg::WIDTH_RESET;
  logic [sbm_pkg::CFG_BINS_W-1:0]    bins_cfg = sbm_pkg::BINS_RESET;
  int                                pos = 0;
  int                                zcnt = 0;
  int                                lo_idx = 0;
  int                                hi_idx = 0;
  logic [sbm_pkg::FRAC_W-1:0]        held = '0;
  bit                                keep_inside = 1'b0;
  bit                                band_on = 1'b0;

  bin_t bin_q[$];
  res_t mask_q[$];
  bin_t cur_bin;
  res_t got, want;
  bit   steady = 1'b0;
  int   mismatches = 0;
  int   checked = 0;
  int   spectra = 0;
  int   settings = 0;
  int   rand_bins = 0;

  function automatic int band_index(longint d, longint w, int n);
    if (w == 0) return 0;
    return int'((2 * d * n + w) / (2 * w));
  endfunction

  function automatic res_t mask_bin(bin_t b);
    res_t   r;
    int     n;
    bit     zero;
    longint a, bb, f, w, lo, hi, bot, top, kept, nf;
    n = (bins_cfg > sbm_pkg::MAX_BINS) ? sbm_pkg::MAX_BINS : int'(bins_cfg);
    if (pos == 0) begin
      a = edge_a;
      bb = edge_b;
      f = $signed(b.freq);
      w = longint'(sb_width);
      lo = (a < bb) ? a : bb;
      hi = (a < bb) ? bb : a;
      band_on = !(a == bb || (a == 0 && bb == sbm_pkg::FULL_SPAN));
      keep_inside = a < bb;
      held = b.frac;
      if (!b.lsb) begin
        bot = f;
        top = f + w;
        lo_idx = lo < bot ? -1 : lo < top ? band_index(lo - bot, w, n) : n + 1;
        hi_idx = hi < bot ? -1 : hi < top ? band_index(hi - bot, w, n) : n + 1;
      end else begin
        top = f;
        bot = f - w;
        lo_idx = hi < bot ? n + 1 : hi < top ? band_index(top - hi, w, n) : -1;
        hi_idx = lo < bot ? n + 1 : lo < top ? band_index(top - lo, w, n) : -1;
      end
    end
    zero = 1'b0;
    if (band_on && pos < n) begin
      if (keep_inside) zero = (pos < lo_idx) || (pos > hi_idx);
      else zero = (pos > lo_idx) && (pos < hi_idx);
      if (zero) zcnt++;
    end
    r = '0;
    r.re = zero ? '0 : b.re;
    r.im = zero ? '0 : b.im;
    r.eos = b.last;
    r.act = band_on;
    if (b.last) begin
      if (!band_on) begin
        r.ratio = sbm_pkg::RATIO_ONE;
        r.nfrac = held;
      end else begin
        r.zeroed = zcnt[sbm_pkg::BIN_W-1:0];
        if (zcnt < n) begin
          kept = n - zcnt;
          nf = (longint'(held) * n * 2 + kept) / (2 * kept);
          r.ratio = sbm_pkg::RATIO_W'((kept * 131072 + n) / (2 * n));
          r.nfrac = (nf > longint'(sbm_pkg::FRAC_MAX)) ? sbm_pkg::FRAC_MAX
                                                       : nf[sbm_pkg::FRAC_W-1:0];
        end
        r.sfrac = held;
      end
      pos = 0;
      zcnt = 0;
    end else if (pos < sbm_pkg::MAX_BINS) begin
      pos++;
    end
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) mask_q.push_back(mask_bin(cur_bin));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (bin_q.size() != 0 && (steady || $urandom_range(99) >= 17)) begin
          cur_bin = bin_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {cur_bin.frac, cur_bin.freq, cur_bin.im, cur_bin.re};
          s_axis_tuser <= cur_bin.lsb;
          s_axis_tlast <= cur_bin.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic string res_str(res_t r);
    return $sformatf("re=%h im=%h last=%b act=%b zeroed=%0d ratio=%0d new=%h saved=%h",
                     r.re, r.im, r.eos, r.act, r.zeroed, r.ratio, r.nfrac, r.sfrac);
  endfunction

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast, m_axis_tuser,
               m_axis_tdata[76:64], m_axis_tdata[93:77], m_axis_tdata[117:94],
               m_axis_tdata[141:118]};
        checked++;
        if (mask_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", res_str(got));
        end else begin
          want = mask_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch on result %0d", checked);
              $display("  expected %s", res_str(want));
              $display("  actual   %s", res_str(got));
            end
          end
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 17);
    end
  end

  task automatic settle();
    while (bin_q.size() != 0 || s_axis_tvalid || mask_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [sbm_pkg::CFG_IDX_W-1:0] idx,
                           logic [sbm_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic program_band(logic [sbm_pkg::FREQ_W-1:0] a,
                              logic [sbm_pkg::FREQ_W-1:0] b,
                              logic [sbm_pkg::WIDTH_W-1:0] w,
                              logic [sbm_pkg::CFG_BINS_W-1:0] nbins);
    settle();
    repeat (8) @(posedge clk);
    write_reg(sbm_pkg::CFG_EDGE_A, a);
    write_reg(sbm_pkg::CFG_EDGE_B, b);
    write_reg(sbm_pkg::CFG_WIDTH, sbm_pkg::CFG_DATA_W'(w));
    write_reg(sbm_pkg::CFG_BINS, sbm_pkg::CFG_DATA_W'(nbins));
    @(posedge clk);
    cfg_we <= 1'b0;
    edge_a = a;
    edge_b = b;
    sb_width = w;
    bins_cfg = nbins;
    settings++;
  endtask

  task automatic add_spectrum(int len, bit lsb, logic [sbm_pkg::FREQ_W-1:0] freq,
                              logic [sbm_pkg::FRAC_W-1:0] frac, bit corners);
    bin_t b;
    for (int k = 0; k < len; k++) begin
      b.re = corners ? CORNER[k % 4] : sbm_pkg::DATA_W'($urandom);
      b.im = corners ? CORNER[(k + 1) % 4] : sbm_pkg::DATA_W'($urandom);
      b.lsb = lsb;
      b.freq = freq;
      b.frac = frac;
      b.last = (k == len - 1);
      bin_q.push_back(b);
    end
    spectra++;
  endtask

  function automatic longint spread(longint w);
    longint r;
    r = longint'({$urandom, $urandom} >> 1);
    return (r % (4 * w + 1)) - 2 * w;
  endfunction

  function automatic logic [sbm_pkg::FREQ_W-1:0] rnd40();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[sbm_pkg::FREQ_W-1:0];
  endfunction

  initial begin
    logic [sbm_pkg::WIDTH_W-1:0]    w;
    logic [sbm_pkg::CFG_BINS_W-1:0] nbins;
    logic [sbm_pkg::FRAC_W-1:0]     frac;
    longint                         c, a, b;
    int                             n, len, count;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: full span, nothing masked
    add_spectrum(3, 1'b0, {1'b0, {(sbm_pkg::FREQ_W-1){1'b1}}}, sbm_pkg::FRAC_MAX, 1'b1);
    // keep band in upper sideband, then a band entirely above it
    program_band(sbm_pkg::FREQ_W'(4 * MHZ), sbm_pkg::FREQ_W'(12 * MHZ),
                 sbm_pkg::WIDTH_W'(16 * MHZ), 13'd4);
    add_spectrum(4, 1'b0, '0, sbm_pkg::FRAC_MAX, 1'b1);
    add_spectrum(4, 1'b0, sbm_pkg::FREQ_W'(-100 * MHZ), 24'h012345, 1'b0);
    // notch in lower sideband
    program_band(sbm_pkg::FREQ_W'(12 * MHZ), sbm_pkg::FREQ_W'(4 * MHZ),
                 sbm_pkg::WIDTH_W'(16 * MHZ), 13'd4);
    add_spectrum(4, 1'b1, sbm_pkg::FREQ_W'(16 * MHZ), '0, 1'b1);
    // equal edges
    program_band(sbm_pkg::FREQ_W'(7 * MHZ), sbm_pkg::FREQ_W'(7 * MHZ),
                 sbm_pkg::WIDTH_W'(16 * MHZ), 13'd4);
    add_spectrum(2, 1'b1, sbm_pkg::FREQ_W'(8 * MHZ), 24'h00ffff, 1'b0);
    // zero sideband width
    program_band(sbm_pkg::FREQ_W'(-3 * MHZ), sbm_pkg::FREQ_W'(5 * MHZ), '0, 13'd4);
    add_spectrum(2, 1'b0, '0, 24'h010000, 1'b0);
    // no bins in use
    program_band({1'b1, {(sbm_pkg::FREQ_W-1){1'b0}}}, {1'b0, {(sbm_pkg::FREQ_W-1){1'b1}}},
                 '1, '0);
    add_spectrum(2, 1'b0, '0, 24'h800000, 1'b0);
    // more bins than configured
    program_band(sbm_pkg::FREQ_W'(2 * MHZ), sbm_pkg::FREQ_W'(9 * MHZ),
                 sbm_pkg::WIDTH_W'(16 * MHZ), 13'd2);
    add_spectrum(4, 1'b0, '0, 24'h020000, 1'b1);

    // long spectrum with no idling on either side
    program_band(sbm_pkg::FREQ_W'(-20 * MHZ), sbm_pkg::FREQ_W'(300 * MHZ),
                 sbm_pkg::WIDTH_W'(1024 * MHZ), 13'd160);
    steady = 1'b1;
    add_spectrum(164, 1'b0, '0, 24'h010000, 1'b0);
    settle();
    steady = 1'b0;

    while (rand_bins < 1360) begin
      case ($urandom_range(11))
        0: w = '0;
        1: w = sbm_pkg::WIDTH_W'(1);
        2: w = '1;
        default: begin
          w = sbm_pkg::WIDTH_W'({$urandom, $urandom} >> $urandom_range(28, 58));
          if (w == 0) w = sbm_pkg::WIDTH_W'(1);
        end
      endcase
      case ($urandom_range(15))
        0: nbins = '0;
        1: nbins = 13'd4096;
        2: nbins = '1;
        3: nbins = 13'd1;
        default: nbins = sbm_pkg::CFG_BINS_W'($urandom_range(2, 24));
      endcase
      c = $signed(rnd40());
      case ($urandom_range(11))
        0: begin a = c; b = c; end
        1: begin a = 0; b = sbm_pkg::FULL_SPAN; end
        2: begin a = -(64'sd1 <<< 39); b = (64'sd1 <<< 39) - 1; end
        3: begin a = (64'sd1 <<< 39) - 1; b = -(64'sd1 <<< 39); end
        default: begin a = c + spread(w); b = c + spread(w); end
      endcase
      program_band(a[sbm_pkg::FREQ_W-1:0], b[sbm_pkg::FREQ_W-1:0], w, nbins);
      n = (nbins > sbm_pkg::MAX_BINS) ? sbm_pkg::MAX_BINS : int'(nbins);
      count = int'($urandom_range(1, 5));
      for (int s = 0; s < count; s++) begin
        if (n == 0) len = int'($urandom_range(1, 6));
        else if (n > 64) len = int'($urandom_range(1, 40));
        else case ($urandom_range(9))
          0: len = int'($urandom_range(1, n));
          1: len = n + int'($urandom_range(1, 3));
          default: len = n;
        endcase
        case ($urandom_range(7))
          0: frac = '0;
          1: frac = sbm_pkg::FRAC_MAX;
          default: frac = sbm_pkg::FRAC_W'($urandom);
        endcase
        add_spectrum(len, 1'($urandom), ($urandom_range(7) == 0) ? rnd40() :
                     sbm_pkg::FREQ_W'(c + spread(w)), frac, $urandom_range(9) == 0);
        rand_bins += len;
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("checked %0d output bins from %0d spectra across %0d band settings",
             checked, spectra, settings);
    $display("covered pass-through, keep and notch bands, both sidebands, degenerate sizes");
    if (mismatches == 0 && mask_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("FAILURE");
    $finish;
  end

endmodule
